// File: rtl/sexpr_reader_scanner_assert.svh
// ----------------------------------------------------------------------------
// S-expression reader scanner: assertion macros
// Shared macros for the concurrent checks on the scanner's ports.
// ----------------------------------------------------------------------------
`ifndef SEXPR_READER_SCANNER_ASSERT_SVH
`define SEXPR_READER_SCANNER_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define SRS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define SRS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also runs during reset.
`define SRS_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/srs_pkg.sv
// ----------------------------------------------------------------------------
// S-expression reader scanner package
// Character codes, mode flags and the result record shared by the modules.
// ----------------------------------------------------------------------------
package srs_pkg;

    // Characters with a special meaning to the scanner.
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_SEMICOLON = 8'h3B;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_NUL       = 8'h00;

    // Mode flags of the scanner.
    typedef struct packed {
        logic in_string;
        logic in_comment;
        logic escape_pending;
        logic before_token;
        logic after_space;
    } srs_flags_t;

    // One result item as it leaves the block.
    typedef struct packed {
        logic              emit_valid;
        logic [7:0]        emit_char;
        logic              expr_done;
        logic              at_eof;
        logic signed [7:0] paren_depth;
        logic [15:0]       first_row;
        logic [15:0]       first_col;
        logic [15:0]       last_row;
        logic [15:0]       last_col;
    } srs_result_t;

endpackage

// File: rtl/sexpr_reader_scanner.sv
// ----------------------------------------------------------------------------
// S-expression reader scanner
// Takes one source character per item, drops comments, normalises
// whitespace, tracks nesting depth and positions, and flags complete
// expressions at depth zero.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Payload
//  s_        in         s_valid / s_ready   ch, end_of_input
//  m_        out        m_valid / m_ready   emit, done, eof, depth, positions
//
// Every item gives exactly one result item, which appears in the cycle after acceptance.
// An item may be accepted in every cycle while the output is not stalled; the
// throughput is set by the single state update per character.
// The output register frees itself in the cycle its item is taken, so a new
// item is accepted while a finished result is being taken.
// Reset is synchronous and active low; it restores the initial scanner state.
// ----------------------------------------------------------------------------
module sexpr_reader_scanner #(
    parameter int POS_BITS   = 16,
    parameter int DEPTH_BITS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_ch,
    input  logic              s_end_of_input,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_emit_valid,
    output logic [7:0]        m_emit_char,
    output logic              m_expr_done,
    output logic              m_at_eof,
    output logic signed [7:0] m_paren_depth,
    output logic [15:0]       m_first_row,
    output logic [15:0]       m_first_col,
    output logic [15:0]       m_last_row,
    output logic [15:0]       m_last_col
);

    localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

    srs_pkg::srs_flags_t          flags_reg, flags_next;
    logic signed [DEPTH_BITS-1:0] depth_reg, depth_next;
    logic [POS_BITS-1:0]          start_row_reg, start_row_next;
    logic [POS_BITS-1:0]          start_col_reg, start_col_next;
    logic [POS_BITS-1:0]          end_row_reg, end_row_next;
    logic [POS_BITS-1:0]          end_col_reg, end_col_next;
    srs_pkg::srs_result_t         result_reg, result_next;
    logic                         m_valid_reg;
    logic                         accept;

    // Per-character logic.
    srs_step #(
        .POS_BITS   (POS_BITS),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_step (
        .ch             (s_ch),
        .end_of_input   (s_end_of_input),
        .flags_cur      (flags_reg),
        .depth_cur      (depth_reg),
        .start_row_cur  (start_row_reg),
        .start_col_cur  (start_col_reg),
        .end_row_cur    (end_row_reg),
        .end_col_cur    (end_col_reg),
        .flags_next     (flags_next),
        .depth_next     (depth_next),
        .start_row_next (start_row_next),
        .start_col_next (start_col_next),
        .end_row_next   (end_row_next),
        .end_col_next   (end_col_next),
        .result         (result_next)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Scanner state, updated once per accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg     <= '{in_string: 1'b0, in_comment: 1'b0, escape_pending: 1'b0,
                               before_token: 1'b1, after_space: 1'b0};
            depth_reg     <= '0;
            start_row_reg <= POS_ONE;
            start_col_reg <= POS_ONE;
            end_row_reg   <= POS_ONE;
            end_col_reg   <= POS_ONE;
        end else if (accept) begin
            flags_reg     <= flags_next;
            depth_reg     <= depth_next;
            start_row_reg <= start_row_next;
            start_col_reg <= start_col_next;
            end_row_reg   <= end_row_next;
            end_col_reg   <= end_col_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_emit_valid  = result_reg.emit_valid;
    assign m_emit_char   = result_reg.emit_char;
    assign m_expr_done   = result_reg.expr_done;
    assign m_at_eof      = result_reg.at_eof;
    assign m_paren_depth = result_reg.paren_depth;
    assign m_first_row   = result_reg.first_row;
    assign m_first_col   = result_reg.first_col;
    assign m_last_row    = result_reg.last_row;
    assign m_last_col    = result_reg.last_col;

endmodule

// File: rtl/srs_step.sv
// ----------------------------------------------------------------------------
// S-expression reader scanner step
// Next-state and result logic for one character item.
// ----------------------------------------------------------------------------
module srs_step #(
    parameter int POS_BITS   = 16,
    parameter int DEPTH_BITS = 8
) (
    input  logic [7:0]                   ch,
    input  logic                         end_of_input,
    input  srs_pkg::srs_flags_t          flags_cur,
    input  logic signed [DEPTH_BITS-1:0] depth_cur,
    input  logic [POS_BITS-1:0]          start_row_cur,
    input  logic [POS_BITS-1:0]          start_col_cur,
    input  logic [POS_BITS-1:0]          end_row_cur,
    input  logic [POS_BITS-1:0]          end_col_cur,
    output srs_pkg::srs_flags_t          flags_next,
    output logic signed [DEPTH_BITS-1:0] depth_next,
    output logic [POS_BITS-1:0]          start_row_next,
    output logic [POS_BITS-1:0]          start_col_next,
    output logic [POS_BITS-1:0]          end_row_next,
    output logic [POS_BITS-1:0]          end_col_next,
    output srs_pkg::srs_result_t         result
);

    localparam int DW = (DEPTH_BITS > 8) ? DEPTH_BITS : 8;
    localparam int PW = (POS_BITS > 16) ? POS_BITS : 16;
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

    // Saturating increment of a position counter.
    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        return (&v) ? v : POS_BITS'(v + 1'b1);
    endfunction

    srs_pkg::srs_flags_t          f;
    logic signed [DEPTH_BITS-1:0] d;
    logic [POS_BITS-1:0]          sr, sc, er, ec;
    logic                         ev, check, done, is_nl, is_ws;
    logic [7:0]                   ech;
    logic signed [DW-1:0]         depth_ext;
    logic [PW-1:0]                sr_ext, sc_ext, er_ext, ec_ext;

    assign is_nl = (ch == srs_pkg::CH_NEWLINE);
    assign is_ws = (ch == srs_pkg::CH_SPACE) || (ch >= srs_pkg::CH_TAB && ch <= srs_pkg::CH_CR);

    always_comb begin
        // Row and column tracking; the start position follows only before a token.
        er = end_row_cur;
        ec = end_col_cur;
        sr = start_row_cur;
        sc = start_col_cur;
        if (is_nl) begin
            er = sat_inc(end_row_cur);
            ec = POS_ONE;
            if (flags_cur.before_token) begin
                sr = sat_inc(start_row_cur);
                sc = POS_ONE;
            end
        end else begin
            ec = sat_inc(end_col_cur);
            if (flags_cur.before_token) begin
                sc = sat_inc(start_col_cur);
            end
        end

        // Mode handling.
        f     = flags_cur;
        d     = depth_cur;
        ev    = 1'b0;
        ech   = srs_pkg::CH_NUL;
        check = 1'b0;
        if (flags_cur.in_string) begin
            ev  = 1'b1;
            ech = ch;
            if (flags_cur.escape_pending) begin
                f.escape_pending = 1'b0;
            end else if (ch == srs_pkg::CH_BACKSLASH) begin
                f.escape_pending = 1'b1;
            end else if (ch == srs_pkg::CH_QUOTE) begin
                f.in_string = 1'b0;
            end
        end else if (flags_cur.in_comment) begin
            if (is_nl) begin
                f.in_comment = 1'b0;
            end
        end else begin
            f.escape_pending = 1'b0;
            check            = 1'b1;
            case (ch)
                srs_pkg::CH_LPAREN: begin
                    ev  = 1'b1;
                    ech = ch;
                    if (depth_cur != DEPTH_MAX) begin
                        d = DEPTH_BITS'(depth_cur + 1'b1);
                    end
                    f.before_token = 1'b0;
                    f.after_space  = 1'b0;
                end
                srs_pkg::CH_RPAREN: begin
                    ev  = 1'b1;
                    ech = ch;
                    if (depth_cur != DEPTH_MIN) begin
                        d = DEPTH_BITS'(depth_cur - 1'b1);
                    end
                    f.before_token = 1'b0;
                    f.after_space  = 1'b0;
                end
                srs_pkg::CH_QUOTE: begin
                    ev             = 1'b1;
                    ech            = ch;
                    f.in_string    = 1'b1;
                    f.before_token = 1'b0;
                    f.after_space  = 1'b0;
                end
                srs_pkg::CH_SEMICOLON: begin
                    f.in_comment  = 1'b1;
                    f.after_space = 1'b0;
                    check         = 1'b0;
                end
                default: begin
                    if (is_ws) begin
                        // A newline is emitted, as a space, only inside parentheses.
                        if (!is_nl || (!depth_cur[DEPTH_BITS-1] && depth_cur != '0)) begin
                            ev  = 1'b1;
                            ech = srs_pkg::CH_SPACE;
                        end
                        f.after_space = 1'b1;
                    end else begin
                        ev             = 1'b1;
                        ech            = ch;
                        f.before_token = 1'b0;
                        f.after_space  = 1'b0;
                    end
                end
            endcase
        end

        done = check && (f.after_space || !f.before_token) && (d == '0);

        // End of text leaves the state alone and reports it as it stands.
        if (end_of_input) begin
            ev   = 1'b0;
            ech  = srs_pkg::CH_NUL;
            done = 1'b0;
            f    = flags_cur;
            d    = depth_cur;
            sr   = start_row_cur;
            sc   = start_col_cur;
            er   = end_row_cur;
            ec   = end_col_cur;
        end

        // The result shows the values before re-arming.
        depth_ext          = DW'(d);
        sr_ext             = PW'(sr);
        sc_ext             = PW'(sc);
        er_ext             = PW'(er);
        ec_ext             = PW'(ec);
        result.emit_valid  = ev;
        result.emit_char   = ech;
        result.expr_done   = done;
        result.at_eof      = end_of_input;
        result.paren_depth = depth_ext[7:0];
        result.first_row   = sr_ext[15:0];
        result.first_col   = sc_ext[15:0];
        result.last_row    = er_ext[15:0];
        result.last_col    = ec_ext[15:0];

        // A finished expression re-arms the scanner at the end position.
        flags_next     = f;
        depth_next     = d;
        start_row_next = sr;
        start_col_next = sc;
        end_row_next   = er;
        end_col_next   = ec;
        if (done) begin
            flags_next.in_string      = 1'b0;
            flags_next.in_comment     = 1'b0;
            flags_next.escape_pending = 1'b0;
            flags_next.before_token   = 1'b1;
            flags_next.after_space    = 1'b0;
            depth_next                = '0;
            start_row_next            = er;
            start_col_next            = ec;
        end
    end

endmodule

// File: rtl/srs_checker.sv
// ----------------------------------------------------------------------------
// S-expression reader scanner checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "sexpr_reader_scanner_assert.svh"

module srs_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_emit_valid,
    input logic [7:0]        m_emit_char,
    input logic              m_expr_done,
    input logic              m_at_eof,
    input logic signed [7:0] m_paren_depth
);

    // An end-of-text item neither emits nor completes an expression.
    `SRS_ASSERT_NOW(a_eof_quiet, aclk, aresetn, m_valid && m_at_eof, !m_emit_valid && !m_expr_done, "end-of-text item emits or completes")

    // A silent item carries a zero character.
    `SRS_ASSERT_NOW(a_silent_zero, aclk, aresetn, m_valid && !m_emit_valid, m_emit_char == 8'h00, "character present without emit")

    // An expression completes only at depth zero.
    `SRS_ASSERT_NOW(a_done_depth, aclk, aresetn, m_valid && m_expr_done, m_paren_depth == 8'sh00, "expression completed away from depth zero")

    // A stalled result item holds its payload.
    `SRS_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_emit_char) && $stable(m_paren_depth), "stalled result item changed")

    // No result item is shown straight after reset.
    `SRS_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid, "result item valid after reset")

endmodule

bind sexpr_reader_scanner srs_checker u_srs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_emit_valid  (m_emit_valid),
    .m_emit_char   (m_emit_char),
    .m_expr_done   (m_expr_done),
    .m_at_eof      (m_at_eof),
    .m_paren_depth (m_paren_depth)
);
